// File: rtl/sfpg_pkg.sv
`timescale 1ns / 1ps

package sfpg_pkg;

  localparam int DivCells = 42;
  localparam int TayCells = 7;

  localparam logic [2:0] REG_PERIOD     = 3'd0;
  localparam logic [2:0] REG_SHIFT_IDX  = 3'd1;
  localparam logic [2:0] REG_SHIFT_CNT  = 3'd2;
  localparam logic [2:0] REG_HORIZONTAL = 3'd3;

  typedef struct packed {
    logic        valid;
    logic [17:0] a;
    logic [16:0] rem;
    logic [16:0] m;
    logic [23:0] q;
  } div_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         quad;
    logic [31:0]        x2;
    logic [30:0]        term;
    logic signed [33:0] sum;
  } tay_t;

  // Divisor (2k)(2k+1) of Taylor term k.
  function automatic logic [7:0] tay_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd1: d = 8'd6;
      3'd2: d = 8'd20;
      3'd3: d = 8'd42;
      3'd4: d = 8'd72;
      3'd5: d = 8'd110;
      3'd6: d = 8'd156;
      3'd7: d = 8'd210;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^36 / divisor), so that the product underestimates by at most one.
  function automatic logic [33:0] tay_recip(input logic [2:0] k);
    logic [33:0] r;
    case (k)
      3'd1: r = 34'd11453246122;
      3'd2: r = 34'd3435973836;
      3'd3: r = 34'd1636178017;
      3'd4: r = 34'd954437176;
      3'd5: r = 34'd624722515;
      3'd6: r = 34'd440509466;
      3'd7: r = 34'd327235603;
      default: r = 34'd11453246122;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/sfpg_div_cell.sv
`timescale 1ns / 1ps

module sfpg_div_cell import sfpg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  div_t d_in,
  output div_t d_out
);

  div_t        d_r;
  div_t        d_nxt;
  logic [17:0] trial;
  logic        ge;
  logic [17:0] diff;

  always_comb begin
    trial = {d_in.rem, d_in.a[17]};
    ge    = trial >= {1'b0, d_in.m};
    diff  = trial - {1'b0, d_in.m};
    d_nxt       = d_in;
    d_nxt.a     = {d_in.a[16:0], 1'b0};
    d_nxt.rem   = ge ? diff[16:0] : trial[16:0];
    d_nxt.q     = {d_in.q[22:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// File: rtl/sfpg_taylor_cell.sv
`timescale 1ns / 1ps

module sfpg_taylor_cell import sfpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [2:0] k,
  input  tay_t       t_in,
  output tay_t       t_out
);

  tay_t        s1_r, s2_r, s3_r;
  tay_t        s3_nxt;
  logic [32:0] p1_r;
  logic [32:0] p2_r;
  logic [30:0] q0_r;
  logic [62:0] prod_tx;
  logic [66:0] prod_pm;
  logic [38:0] prod_qd;
  logic [38:0] rem;
  logic [7:0]  d;
  logic [30:0] q;

  assign d       = tay_div(k);
  assign prod_tx = t_in.term * t_in.x2;
  assign prod_pm = p1_r * tay_recip(k);

  // The reciprocal estimate is exact or one short; a single compare fixes it.
  always_comb begin
    prod_qd = q0_r * d;
    rem     = {6'd0, p2_r} - prod_qd;
    q       = (rem >= {31'd0, d}) ? q0_r + 31'd1 : q0_r;
    s3_nxt      = s2_r;
    s3_nxt.term = q;
    if (k[0]) begin
      s3_nxt.sum = s2_r.sum - $signed({3'd0, q});
    end else begin
      s3_nxt.sum = s2_r.sum + $signed({3'd0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s1_r <= t_in;
      p1_r <= prod_tx[62:30];
      s2_r <= s1_r;
      p2_r <= p1_r;
      q0_r <= prod_pm[66:36];
      s3_r <= s3_nxt;
    end
  end

  assign t_out = s3_r;

endmodule

// File: rtl/sinusoidal_fringe_pixel_generator.sv
`timescale 1ns / 1ps
// Pipeline: the 42 restoring divider cells, the seven three-stage Taylor cells and four
// single stages lie between input transfer and result.
// Throughput: one pixel per cycle; a stalled result holds the whole pipeline.
// Reset: synchronous, active low; clears all valid flags and loads period 32,
// shift index 0, shift count 4 and horizontal mode.
module sinusoidal_fringe_pixel_generator import sfpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_column,
  input  logic [11:0] in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_intensity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic [11:0] period_r;
  logic [3:0]  shift_idx_r;
  logic [4:0]  shift_cnt_r;
  logic        horiz_r;

  logic        en;
  logic        out_valid_r;
  logic [7:0]  out_intensity_r;

  div_t        div_s [0:DivCells];
  tay_t        tay_s [0:TayCells];

  logic [11:0] coord;
  logic [11:0] period_eff;
  logic [4:0]  count_eff;
  logic [16:0] prod_cc;
  logic [15:0] prod_ip;
  div_t        front_nxt;

  logic        xs_valid_r;
  logic [1:0]  xs_quad_r;
  logic [30:0] x_r;
  logic [22:0] ur;
  logic [53:0] xprod;
  logic [61:0] x2prod;
  tay_t        x2_r;

  logic [33:0] rnd;
  logic [19:0] s_abs;
  logic [16:0] s_lim;
  logic [17:0] base;
  logic [24:0] scaled;
  logic [7:0]  v;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= 12'd32;
      shift_idx_r <= 4'd0;
      shift_cnt_r <= 5'd4;
      horiz_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD:     period_r    <= cfg_data;
        REG_SHIFT_IDX:  shift_idx_r <= cfg_data[3:0];
        REG_SHIFT_CNT:  shift_cnt_r <= cfg_data[4:0];
        REG_HORIZONTAL: horiz_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Dividing (a << 24) by m leaves frac(a / m) in the low 24 quotient bits.
  always_comb begin
    coord      = horiz_r ? in_row : in_column;
    period_eff = (period_r == 12'd0) ? 12'd1 : period_r;
    count_eff  = (shift_cnt_r == 5'd0) ? 5'd1 : shift_cnt_r;
    prod_cc    = {5'd0, coord} * {12'd0, count_eff};
    prod_ip    = {12'd0, shift_idx_r} * {4'd0, period_eff};
    front_nxt.valid = in_valid;
    front_nxt.a     = {1'b0, prod_cc} + {2'd0, prod_ip};
    front_nxt.rem   = 17'd0;
    front_nxt.m     = {5'd0, period_eff} * {12'd0, count_eff};
    front_nxt.q     = 24'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_s[0].valid <= 1'b0;
    end else if (en) begin
      div_s[0] <= front_nxt;
    end
  end

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    sfpg_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (div_s[i]),
      .d_out (div_s[i+1])
    );
  end

  // Odd quadrants run the angle backwards from a quarter turn.
  always_comb begin
    ur     = div_s[DivCells].q[22] ? (23'h400000 - {1'b0, div_s[DivCells].q[21:0]})
                                   : {1'b0, div_s[DivCells].q[21:0]};
    xprod  = ur * 31'd1686629713;
    x2prod = x_r * x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_valid_r <= 1'b0;
      x2_r.valid <= 1'b0;
    end else if (en) begin
      xs_valid_r <= div_s[DivCells].valid;
      xs_quad_r  <= div_s[DivCells].q[23:22];
      x_r        <= xprod[52:22];
      x2_r.valid <= xs_valid_r;
      x2_r.quad  <= xs_quad_r;
      x2_r.x2    <= x2prod[61:30];
      x2_r.term  <= x_r;
      x2_r.sum   <= $signed({3'd0, x_r});
    end
  end

  assign tay_s[0] = x2_r;

  for (genvar j = 0; j < TayCells; j++) begin : g_tay
    sfpg_taylor_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .k     (3'(j + 1)),
      .t_in  (tay_s[j]),
      .t_out (tay_s[j+1])
    );
  end

  always_comb begin
    rnd    = tay_s[TayCells].sum[33] ? 34'd0 : 34'(tay_s[TayCells].sum) + 34'd8192;
    s_abs  = rnd[33:14];
    s_lim  = (s_abs > 20'd65536) ? 17'd65536 : s_abs[16:0];
    base   = tay_s[TayCells].quad[1] ? 18'd65536 - {1'b0, s_lim}
                                     : 18'd65536 + {1'b0, s_lim};
    scaled = base * 7'd127;
    v      = (scaled[24:16] > 9'd254) ? 8'd254 : scaled[23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r     <= tay_s[TayCells].valid;
      out_intensity_r <= v;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_intensity = out_intensity_r;

endmodule
